### rtl/pn2d_pkg.sv
package pn2d_pkg;

    localparam int TABLE_SIZE    = 256;
    localparam int FRACTION_BITS = 16;

    localparam int COORD_W = 24;
    localparam int OUT_W   = 18;
    localparam int BYTE_W  = 8;
    localparam int FRAC_W  = FRACTION_BITS;
    localparam int INT_W   = COORD_W - FRAC_W;
    localparam int IDX_W   = $clog2(TABLE_SIZE);

    localparam int ONE     = 1 << FRAC_W;
    localparam int TEN_S   = 10 * ONE;
    localparam int C_SIX   = 6;
    localparam int C_FIFTN = 15;

    // fade datapath
    localparam int SQ_W   = 2 * FRAC_W;
    localparam int Q_W    = FRAC_W + 4;
    localparam int QS_W   = Q_W + 1;
    localparam int FQ_W   = FRAC_W + Q_W;
    localparam int FADE_W = FRAC_W + 1;

    // gradient / blend datapath
    localparam int GRAD_W = FRAC_W + 3;
    localparam int DIFF_W = GRAD_W + 1;
    localparam int LERP_W = DIFF_W;
    localparam int E_W    = LERP_W + 1;
    localparam int P0_W   = FADE_W + 1 + DIFF_W;
    localparam int P1_W   = FADE_W + 1 + E_W;

    localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN = -(1 << (OUT_W - 1));

    // pipeline depth, accept to output register
    localparam int NSTAGE = 9;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef enum logic [1:0] {
        GRAD_PP = 2'd0,
        GRAD_NP = 2'd1,
        GRAD_PN = 2'd2,
        GRAD_NN = 2'd3
    } grad_sel_t;

    function automatic logic signed [GRAD_W-1:0] grad_fn(
        input logic [1:0]               hash,
        input logic signed [GRAD_W-1:0] dx,
        input logic signed [GRAD_W-1:0] dy
    );
        logic signed [GRAD_W-1:0] res;
        case (grad_sel_t'(hash))
            GRAD_PP: res = dx + dy;
            GRAD_NP: res = dy - dx;
            GRAD_PN: res = dx - dy;
            default: res = -dx - dy;
        endcase
        return res;
    endfunction

endpackage

### rtl/perlin_noise_2d_top.sv
// Channel | Direction | Ports                                                  | Handshake
// input   | in        | s_operation s_table_index s_table_value s_x_coord      | s_valid/s_ready
//         |           | s_y_coord                                              |
// result  | out       | m_noise_value                                          | m_valid/m_ready
//
// One beat per cycle sustained while m_ready stays high; an evaluate beat passes stages 1
// to 8, then the output register. The permutation table is kept in three copies, each with two
// read ports, read at stages 1 and 2; a write beat updates each copy at its read stage.
// Reset clears the stage valid bits only; table contents are undefined until written.
// Each stage holds under stall and empty stages fill, so input keeps flowing while a
// result waits, until the pipe is full.
module perlin_noise_2d_top
    import pn2d_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_operation,
    input  logic [7:0]                s_table_index,
    input  logic [7:0]                s_table_value,
    input  logic signed [COORD_W-1:0] s_x_coord,
    input  logic signed [COORD_W-1:0] s_y_coord,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [OUT_W-1:0]   m_noise_value
);

    // table copies: A gives pa/pb, B gives aa/ab, C gives ba/bb
    logic [BYTE_W-1:0] perm_a_mem [TABLE_SIZE];
    logic [BYTE_W-1:0] perm_b_mem [TABLE_SIZE];
    logic [BYTE_W-1:0] perm_c_mem [TABLE_SIZE];

    logic [NSTAGE:1]   vld_reg;
    logic [NSTAGE+1:1] rdy;
    logic [NSTAGE:1]   ld;

    // stage 1
    logic                    p1_op_reg;
    logic [IDX_W-1:0]        p1_widx_reg;
    logic [BYTE_W-1:0]       p1_wval_reg;
    logic [IDX_W-1:0]        p1_yi_reg;
    logic [FRAC_W-1:0]       p1_xf_reg, p1_yf_reg;
    logic [BYTE_W-1:0]       p1_pa_reg, p1_pb_reg;
    // stage 2
    logic [1:0]              p2_haa_reg, p2_hab_reg, p2_hba_reg, p2_hbb_reg;
    logic [FRAC_W-1:0]       p2_xf_reg, p2_yf_reg;
    logic [FRAC_W-1:0]       p2_t2x_reg, p2_t2y_reg;
    // stage 3
    logic [FRAC_W-1:0]       p3_t3x_reg, p3_t3y_reg;
    logic [Q_W-1:0]          p3_qx_reg, p3_qy_reg;
    logic signed [GRAD_W-1:0] p3_g00_reg, p3_g10_reg, p3_g01_reg, p3_g11_reg;
    // stage 4
    logic [FADE_W-1:0]       p4_u_reg, p4_v_reg;
    logic signed [GRAD_W-1:0] p4_g00_reg, p4_g01_reg;
    logic signed [DIFF_W-1:0] p4_d0_reg, p4_d1_reg;
    // stage 5
    logic signed [P0_W-1:0]  p5_p0_reg, p5_p1_reg;
    logic signed [GRAD_W-1:0] p5_g00_reg, p5_g01_reg;
    logic [FADE_W-1:0]       p5_v_reg;
    // stage 6
    logic signed [LERP_W-1:0] p6_x1_reg, p6_x2_reg;
    logic [FADE_W-1:0]       p6_v_reg;
    // stage 7
    logic signed [LERP_W-1:0] p7_x1_reg;
    logic signed [E_W-1:0]   p7_e_reg;
    logic [FADE_W-1:0]       p7_v_reg;
    // stage 8
    logic signed [LERP_W-1:0] p8_x1_reg;
    logic signed [P1_W-1:0]  p8_p_reg;
    // stage 9
    logic signed [OUT_W-1:0] out_reg;

    // ---------------- handshake chain ----------------
    always_comb begin
        rdy[NSTAGE+1] = m_ready;
        for (int k = NSTAGE; k >= 1; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        ld[1] = s_valid && rdy[1];
        for (int k = 2; k <= NSTAGE; k++) begin
            ld[k] = vld_reg[k-1] && rdy[k];
        end
    end

    assign s_ready       = rdy[1];
    assign m_valid       = vld_reg[NSTAGE];
    assign m_noise_value = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[1]) begin
                vld_reg[1] <= s_valid;
            end
            // write beats retire once table copies B and C are updated
            if (rdy[2]) begin
                vld_reg[2] <= vld_reg[1] && (p1_op_reg == OP_EVAL);
            end
            for (int k = 3; k <= NSTAGE; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: split, table copy A ----------------
    logic [IDX_W-1:0] xi_idx, xi1_idx, yi_idx, w_idx;

    assign xi_idx  = IDX_W'($signed(s_x_coord[COORD_W-1:FRAC_W]));
    assign xi1_idx = xi_idx + IDX_W'(1);
    assign yi_idx  = IDX_W'($signed(s_y_coord[COORD_W-1:FRAC_W]));
    assign w_idx   = IDX_W'(s_table_index);

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            if (s_operation == OP_WRITE) begin
                perm_a_mem[w_idx] <= s_table_value;
            end
            p1_pa_reg <= perm_a_mem[xi_idx];
            p1_pb_reg <= perm_a_mem[xi1_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            p1_op_reg   <= s_operation;
            p1_widx_reg <= w_idx;
            p1_wval_reg <= s_table_value;
            p1_yi_reg   <= yi_idx;
            p1_xf_reg   <= s_x_coord[FRAC_W-1:0];
            p1_yf_reg   <= s_y_coord[FRAC_W-1:0];
        end
    end

    // ---------------- stage 2: corner hashes, squares ----------------
    logic [IDX_W-1:0] a_idx, a1_idx, b_idx, b1_idx;
    logic [SQ_W-1:0]  sqx_full, sqy_full;
    logic [FRAC_W-1:0] p2_t2x_next, p2_t2y_next;

    assign a_idx    = IDX_W'(p1_pa_reg) + p1_yi_reg;
    assign a1_idx   = a_idx + IDX_W'(1);
    assign b_idx    = IDX_W'(p1_pb_reg) + p1_yi_reg;
    assign b1_idx   = b_idx + IDX_W'(1);
    assign sqx_full = SQ_W'(p1_xf_reg) * SQ_W'(p1_xf_reg);
    assign sqy_full = SQ_W'(p1_yf_reg) * SQ_W'(p1_yf_reg);
    assign p2_t2x_next = sqx_full[SQ_W-1:FRAC_W];
    assign p2_t2y_next = sqy_full[SQ_W-1:FRAC_W];

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            if (p1_op_reg == OP_WRITE) begin
                perm_b_mem[p1_widx_reg] <= p1_wval_reg;
                perm_c_mem[p1_widx_reg] <= p1_wval_reg;
            end
            p2_haa_reg <= perm_b_mem[a_idx][1:0];
            p2_hab_reg <= perm_b_mem[a1_idx][1:0];
            p2_hba_reg <= perm_c_mem[b_idx][1:0];
            p2_hbb_reg <= perm_c_mem[b1_idx][1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            p2_xf_reg  <= p1_xf_reg;
            p2_yf_reg  <= p1_yf_reg;
            p2_t2x_reg <= p2_t2x_next;
            p2_t2y_reg <= p2_t2y_next;
        end
    end

    // ---------------- stage 3: cubes, fade polynomial, gradients ----------------
    logic [SQ_W-1:0]          cbx_full, cby_full;
    logic [QS_W-1:0]          qx_sum, qy_sum;
    logic signed [GRAD_W-1:0] dx0, dx1, dy0, dy1;

    assign cbx_full = SQ_W'(p2_t2x_reg) * SQ_W'(p2_xf_reg);
    assign cby_full = SQ_W'(p2_t2y_reg) * SQ_W'(p2_yf_reg);
    // 6t^2 + 10 - 15t never goes negative on [0,1)
    assign qx_sum = QS_W'(p2_t2x_reg) * QS_W'(C_SIX) + QS_W'(TEN_S)
                  - QS_W'(p2_xf_reg) * QS_W'(C_FIFTN);
    assign qy_sum = QS_W'(p2_t2y_reg) * QS_W'(C_SIX) + QS_W'(TEN_S)
                  - QS_W'(p2_yf_reg) * QS_W'(C_FIFTN);

    assign dx0 = $signed(GRAD_W'(p2_xf_reg));
    assign dy0 = $signed(GRAD_W'(p2_yf_reg));
    assign dx1 = dx0 - GRAD_W'(ONE);
    assign dy1 = dy0 - GRAD_W'(ONE);

    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            p3_t3x_reg <= cbx_full[SQ_W-1:FRAC_W];
            p3_t3y_reg <= cby_full[SQ_W-1:FRAC_W];
            p3_qx_reg  <= Q_W'(qx_sum);
            p3_qy_reg  <= Q_W'(qy_sum);
            p3_g00_reg <= grad_fn(p2_haa_reg, dx0, dy0);
            p3_g10_reg <= grad_fn(p2_hba_reg, dx1, dy0);
            p3_g01_reg <= grad_fn(p2_hab_reg, dx0, dy1);
            p3_g11_reg <= grad_fn(p2_hbb_reg, dx1, dy1);
        end
    end

    // ---------------- stage 4: fade weights, corner differences ----------------
    logic [FQ_W-1:0] fx_full, fy_full;

    assign fx_full = FQ_W'(p3_t3x_reg) * FQ_W'(p3_qx_reg);
    assign fy_full = FQ_W'(p3_t3y_reg) * FQ_W'(p3_qy_reg);

    always_ff @(posedge aclk) begin
        if (ld[4]) begin
            p4_u_reg   <= fx_full[FRAC_W+FADE_W-1:FRAC_W];
            p4_v_reg   <= fy_full[FRAC_W+FADE_W-1:FRAC_W];
            p4_g00_reg <= p3_g00_reg;
            p4_g01_reg <= p3_g01_reg;
            p4_d0_reg  <= DIFF_W'(p3_g10_reg) - DIFF_W'(p3_g00_reg);
            p4_d1_reg  <= DIFF_W'(p3_g11_reg) - DIFF_W'(p3_g01_reg);
        end
    end

    // ---------------- stage 5: x blend products ----------------
    logic signed [P0_W-1:0] u_ext;

    assign u_ext = P0_W'($signed({1'b0, p4_u_reg}));

    always_ff @(posedge aclk) begin
        if (ld[5]) begin
            p5_p0_reg  <= u_ext * P0_W'(p4_d0_reg);
            p5_p1_reg  <= u_ext * P0_W'(p4_d1_reg);
            p5_g00_reg <= p4_g00_reg;
            p5_g01_reg <= p4_g01_reg;
            p5_v_reg   <= p4_v_reg;
        end
    end

    // ---------------- stage 6: x blend sums ----------------
    logic signed [P0_W-1:0] x1_wide, x2_wide;

    assign x1_wide = P0_W'(p5_g00_reg) + (p5_p0_reg >>> FRAC_W);
    assign x2_wide = P0_W'(p5_g01_reg) + (p5_p1_reg >>> FRAC_W);

    always_ff @(posedge aclk) begin
        if (ld[6]) begin
            p6_x1_reg <= LERP_W'(x1_wide);
            p6_x2_reg <= LERP_W'(x2_wide);
            p6_v_reg  <= p5_v_reg;
        end
    end

    // ---------------- stage 7: y blend difference ----------------
    always_ff @(posedge aclk) begin
        if (ld[7]) begin
            p7_x1_reg <= p6_x1_reg;
            p7_e_reg  <= E_W'(p6_x2_reg) - E_W'(p6_x1_reg);
            p7_v_reg  <= p6_v_reg;
        end
    end

    // ---------------- stage 8: y blend product ----------------
    always_ff @(posedge aclk) begin
        if (ld[8]) begin
            p8_x1_reg <= p7_x1_reg;
            p8_p_reg  <= P1_W'($signed({1'b0, p7_v_reg})) * P1_W'(p7_e_reg);
        end
    end

    // ---------------- stage 9: sum, saturate, output register ----------------
    logic signed [P1_W-1:0]  r_wide;
    logic signed [OUT_W-1:0] out_next;

    assign r_wide = P1_W'(p8_x1_reg) + (p8_p_reg >>> FRAC_W);

    always_comb begin
        if (r_wide > P1_W'(OUT_MAX)) begin
            out_next = OUT_W'(OUT_MAX);
        end else if (r_wide < P1_W'(OUT_MIN)) begin
            out_next = OUT_W'(OUT_MIN);
        end else begin
            out_next = OUT_W'(r_wide);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[9]) begin
            out_reg <= out_next;
        end
    end

endmodule

### rtl/pn2d_checker.sv
module pn2d_checker
    import pn2d_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [OUT_W-1:0] m_noise_value
);

    // nothing comes out the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

    // free output slot means the whole pipe can advance
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled with output slot free");

    // a result that is not taken stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_noise_value))
        else $error("result beat dropped or changed under stall");

    // input-side sanity: ready may only fall while the output is stalled
    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> m_valid && !m_ready)
        else $error("input ready fell without output stall");

endmodule

bind perlin_noise_2d_top pn2d_checker u_pn2d_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_noise_value (m_noise_value)
);

### dv/perlin_noise_2d_top_test.sv
module perlin_noise_2d_top_test;
    import pn2d_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOW_MAX    = 10;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_operation;
    logic [7:0]                s_table_index;
    logic [7:0]                s_table_value;
    logic signed [COORD_W-1:0] s_x_coord;
    logic signed [COORD_W-1:0] s_y_coord;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [OUT_W-1:0]   m_noise_value;

    // mirror of the permutation table, updated in beat order
    logic [7:0]              perm_copy [TABLE_SIZE];
    logic signed [OUT_W-1:0] pending_noise [$];

    bit steady;
    int rx_hold;
    int rx_wait;
    int cycle_cnt;
    int err_cnt;
    int bad_cnt;
    int write_cnt;
    int eval_cnt;
    int noise_seen;

    perlin_noise_2d_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_table_index (s_table_index),
        .s_table_value (s_table_value),
        .s_x_coord     (s_x_coord),
        .s_y_coord     (s_y_coord),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_noise_value (m_noise_value)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("perlin_noise_2d_top_test failed");
            $finish;
        end
    end

    function automatic int idle_draw();
        return steady ? 0 : $urandom_range(5, 0);
    endfunction

    // quintic fade 6t^5 - 15t^4 + 10t^3 on a fraction in [0, ONE)
    function automatic longint fade_q(input longint f);
        longint t2, t3, q;
        t2 = (f * f) >>> FRAC_W;
        t3 = (t2 * f) >>> FRAC_W;
        q  = C_SIX * t2 - C_FIFTN * f + TEN_S;
        return (t3 * q) >>> FRAC_W;
    endfunction

    function automatic longint corner_dot(input logic [7:0] hash, input longint dx,
                                          input longint dy);
        case (grad_sel_t'(hash[1:0]))
            GRAD_PP: return dx + dy;
            GRAD_NP: return dy - dx;
            GRAD_PN: return dx - dy;
            default: return -dx - dy;
        endcase
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint w);
        return a + ((w * (b - a)) >>> FRAC_W);
    endfunction

    function automatic logic [7:0] perm_at(input longint idx);
        return perm_copy[int'(idx & (TABLE_SIZE - 1))];
    endfunction

    function automatic logic signed [OUT_W-1:0] noise_at(
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y
    );
        longint xs, ys, xi, yi, xf, yf, u, v, pa, pb, top, bot, r;
        logic [7:0] aa, ab, ba, bb;
        xs = x;
        ys = y;
        xi = xs >>> FRAC_W;
        yi = ys >>> FRAC_W;
        xf = xs - xi * ONE;
        yf = ys - yi * ONE;
        u  = fade_q(xf);
        v  = fade_q(yf);
        pa = perm_at(xi);
        pb = perm_at(xi + 1);
        aa = perm_at(pa + yi);
        ab = perm_at(pa + yi + 1);
        ba = perm_at(pb + yi);
        bb = perm_at(pb + yi + 1);
        top = blend(corner_dot(aa, xf, yf), corner_dot(ba, xf - ONE, yf), u);
        bot = blend(corner_dot(ab, xf, yf - ONE), corner_dot(bb, xf - ONE, yf - ONE), u);
        r = blend(top, bot, v);
        if (r > OUT_MAX) r = OUT_MAX;
        if (r < OUT_MIN) r = OUT_MIN;
        return r[OUT_W-1:0];
    endfunction

    // sends one beat; s_valid stays high on return so back-to-back beats need no toggle
    task automatic send_beat(input logic op, input logic [7:0] idx, input logic [7:0] val,
                             input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_table_index <= idx;
        s_table_value <= val;
        s_x_coord     <= x;
        s_y_coord     <= y;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (op == OP_EVAL) begin
            pending_noise = {pending_noise, noise_at(x, y)};
            eval_cnt++;
        end else begin
            perm_copy[idx] = val;
            write_cnt++;
        end
    endtask

    task automatic send_write(input logic [7:0] idx, input logic [7:0] val);
        send_beat(OP_WRITE, idx, val, COORD_W'($urandom()), COORD_W'($urandom()));
    endtask

    task automatic send_eval(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
        send_beat(OP_EVAL, 8'($urandom()), 8'($urandom()), x, y);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        logic [15:0] frac;
        case ($urandom_range(3, 0))
            0, 1: return COORD_W'($urandom());
            2: begin
                case ($urandom_range(3, 0))
                    0: frac = 16'h0000;
                    1: frac = 16'h0001;
                    2: frac = 16'hFFFF;
                    default: frac = 16'($urandom());
                endcase
                return {8'($urandom()), frac};
            end
            default: return COORD_W'(int'($urandom_range(6 * ONE, 0)) - 3 * ONE);
        endcase
    endfunction

    task automatic check_noise(input logic signed [OUT_W-1:0] got);
        logic signed [OUT_W-1:0] want;
        noise_seen++;
        if (pending_noise.size() == 0) begin
            err_cnt++;
            $display("noise beat %0d with nothing pending, value %0d", noise_seen, got);
        end else begin
            want = pending_noise.pop_front();
            if (got !== want) begin
                err_cnt++;
                bad_cnt++;
                if (bad_cnt <= SHOW_MAX)
                    $display("noise mismatch on beat %0d: expected %0d, got %0d",
                             noise_seen, want, got);
            end
        end
    endtask

    // result side: per-beat random stall, plus a long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid === 1'b1 && m_ready) begin
                check_noise(m_noise_value);
                rx_wait = idle_draw();
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // every entry gets a value before any evaluate reads it
    task automatic test_table_load();
        int order [TABLE_SIZE];
        int j, t;
        for (int i = 0; i < TABLE_SIZE; i++) order[i] = i;
        for (int i = TABLE_SIZE - 1; i > 0; i--) begin
            j = $urandom_range(i, 0);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < TABLE_SIZE; i++) send_write(8'(i), 8'(order[i]));
    endtask

    task automatic test_corner_points();
        send_eval(24'h000000, 24'h000000);
        send_eval(24'h7FFFFF, 24'h7FFFFF);
        send_eval(24'h800000, 24'h800000);
        send_eval(24'h7FFFFF, 24'h800000);
        send_eval(24'h800000, 24'h7FFFFF);
        send_eval(24'hFFFFFF, 24'hFFFFFF);
        send_eval(24'h000001, 24'h000001);
        send_eval(24'h008000, 24'h008000);
        send_eval(24'h00FFFF, 24'h000000);
        send_eval(24'h000000, 24'h00FFFF);
        send_eval(24'h00FFFF, 24'h00FFFF);
        send_eval(24'h010000, 24'hFF0000);
        send_eval(24'h0C8000, 24'hF38000);
        send_eval(24'h7F0000, 24'h810000);
        send_eval(24'hFF8000, 24'h004000);
        send_eval(24'h800001, 24'h7FFFFE);
    endtask

    // table rewrites followed at once by evaluates that read those entries
    task automatic test_write_then_eval();
        logic [7:0] xi, yi, pv;
        steady = 1'b1;
        for (int k = 0; k < 3; k++) begin
            xi = 8'($urandom());
            yi = 8'($urandom());
            pv = 8'($urandom());
            send_write(xi, pv);
            send_write(pv + yi, 8'($urandom()));
            send_eval({xi, 16'($urandom())}, {yi, 16'($urandom())});
        end
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        rx_hold = 300;
        steady  = 1'b1;
        for (int k = 0; k < 40; k++) send_eval(rand_coord(), rand_coord());
        steady  = 1'b0;
    endtask

    task automatic test_random_mix();
        for (int k = 0; k < 1030; k++) begin
            if (k % 50 == 0) steady = ($urandom_range(3, 0) == 0);
            if ($urandom_range(4, 0) == 0)
                send_write(8'($urandom()), 8'($urandom()));
            else
                send_eval(rand_coord(), rand_coord());
        end
        steady = 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_noise.size() > 0) @(posedge aclk);
        repeat (NSTAGE + 4) @(posedge aclk);
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_operation   <= OP_WRITE;
        s_table_index <= '0;
        s_table_value <= '0;
        s_x_coord     <= '0;
        s_y_coord     <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_table_load();
        test_corner_points();
        test_write_then_eval();
        test_backpressure();
        test_random_mix();
        drain();

        if (pending_noise.size() != 0) begin
            err_cnt++;
            $display("%0d noise results never arrived", pending_noise.size());
        end
        $display("table writes: %0d, evaluates: %0d, results checked: %0d, mismatches: %0d",
                 write_cnt, eval_cnt, noise_seen, bad_cnt);
        $display("points spanned lattice edges, negative cells and full-range coordinates");
        if (err_cnt == 0) begin
            $display("perlin_noise_2d_top_test passed");
        end else begin
            $display("perlin_noise_2d_top_test failed");
        end
        $finish;
    end

endmodule
